// ===== sv/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed distance field pixel block.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Field and register widths
  localparam int COORD_W      = 12;
  localparam int COV_W        = 8;
  localparam int DV_W         = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int DIM_CFG_W    = 11;
  localparam int SPREAD_CFG_W = 9;

  // Signed working width of window coordinates (coordinate plus or minus radius)
  localparam int COORD_WORK_W = 14;

  // Fraction bits of the root, and quotient bits of the final scaling
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 9;

  localparam logic [DIM_CFG_W-1:0]    DIM_RESET    = 11'd1024;
  localparam logic [SPREAD_CFG_W-1:0] SPREAD_RESET = 9'd256;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SPREAD = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CLASS,
    ST_START,
    ST_SCAN,
    ST_SQRT,
    ST_PREP,
    ST_MAP,
    ST_DIV,
    ST_DONE
  } state_e;

  // Scan launch from the sequencer
  typedef struct packed {
    logic start;
    logic cls;
  } scan_ctl_t;

endpackage

// ===== sv/sdf_in_if.sv =====
// ----------------------------------------------------------------------------
// sdf_in_if
// Input item channel: load or query beats with coordinate and coverage.
// ----------------------------------------------------------------------------
interface sdf_in_if;
  import sdf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [COV_W-1:0]          coverage;

  modport source (output valid, kind, coord_x, coord_y, coverage, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, coverage, output ready);
endinterface

// ===== sv/sdf_out_if.sv =====
// ----------------------------------------------------------------------------
// sdf_out_if
// Result channel: one distance byte per query beat.
// ----------------------------------------------------------------------------
interface sdf_out_if;
  import sdf_pkg::*;

  logic            valid;
  logic            ready;
  logic [DV_W-1:0] distance_value;

  modport source (output valid, distance_value, input ready);
  modport sink   (input valid, distance_value, output ready);
endinterface

// ===== sv/sdf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sdf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdf_cfg_if;
  import sdf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sdf_bitmap.sv =====
// ----------------------------------------------------------------------------
// sdf_bitmap
// One-bit bitmap store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sdf_bitmap #(
  parameter int MAX_DIM = 1024
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [2*$clog2(MAX_DIM)-1:0]   waddr_i,
  input  logic                           wdata_i,
  input  logic                           re_i,
  input  logic [2*$clog2(MAX_DIM)-1:0]   raddr_i,
  output logic                           rdata_o
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/sdf_alu.sv =====
// ----------------------------------------------------------------------------
// sdf_alu
// Shared compare-and-subtract unit for the root and scaling iterations.
// ----------------------------------------------------------------------------
module sdf_alu #(
  parameter int W = 32
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         ge_o,
  output logic [W-1:0] diff_o
);

  logic [W:0] sub;

  // one subtractor; the borrow gives the compare
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[W];
  assign diff_o = sub[W-1:0];

endmodule

// ===== sv/sdf_scan.sv =====
// ----------------------------------------------------------------------------
// sdf_scan
// Window scanner: walks the clipped window one pixel a cycle and keeps the
// least squared distance to a pixel of the opposite class.
// ----------------------------------------------------------------------------
module sdf_scan #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_SPREAD = 256
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sdf_pkg::scan_ctl_t                       ctl_i,
  input  logic [$clog2(MAX_DIM)-1:0]               x0_i,
  input  logic [$clog2(MAX_DIM)-1:0]               x1_i,
  input  logic [$clog2(MAX_DIM)-1:0]               y0_i,
  input  logic [$clog2(MAX_DIM)-1:0]               y1_i,
  input  logic signed [sdf_pkg::COORD_WORK_W-1:0]  cx_i,
  input  logic signed [sdf_pkg::COORD_WORK_W-1:0]  cy_i,
  input  logic [2*$clog2(MAX_SPREAD+1)-1:0]        best_init_i,
  output logic                                     rd_en_o,
  output logic [2*$clog2(MAX_DIM)-1:0]             rd_addr_o,
  input  logic                                     rd_data_i,
  output logic                                     done_o,
  output logic [2*$clog2(MAX_SPREAD+1)-1:0]        best_o
);
  import sdf_pkg::*;

  localparam int AW  = $clog2(MAX_DIM);
  localparam int CW  = COORD_WORK_W;
  localparam int SPW = $clog2(MAX_SPREAD + 1);
  localparam int DXW = SPW + 1;
  localparam int BW  = 2 * SPW;

  logic                  active_q, busy_q, s1v_q, s2v_q;
  logic [AW-1:0]         x_q, y_q;
  logic                  cls_q;
  logic signed [DXW-1:0] s1_dx_q, s1_dy_q;
  logic                  s2_hit_q;
  logic [BW-1:0]         sqx_q, sqy_q;
  logic [BW-1:0]         best_q;

  logic signed [CW-1:0]    dx_full, dy_full;
  logic signed [2*DXW-1:0] sqx_full, sqy_full;
  logic [BW:0]             d2;
  logic                    take;

  // offsets of the pixel being read from the query point
  assign dx_full = $signed(CW'(x_q)) - cx_i;
  assign dy_full = $signed(CW'(y_q)) - cy_i;

  assign sqx_full = s1_dx_q * s1_dx_q;
  assign sqy_full = s1_dy_q * s1_dy_q;

  assign d2   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign take = s2v_q && s2_hit_q && (d2 < {1'b0, best_q});

  assign rd_en_o   = active_q;
  assign rd_addr_o = {y_q, x_q};
  assign done_o    = busy_q && !active_q && !s1v_q && !s2v_q;
  assign best_o    = best_q;

  // control: walk row by row, then drain the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      busy_q   <= 1'b0;
      s1v_q    <= 1'b0;
      s2v_q    <= 1'b0;
    end else begin
      s1v_q <= active_q;
      s2v_q <= s1v_q;
      if (ctl_i.start) begin
        active_q <= 1'b1;
        busy_q   <= 1'b1;
      end else begin
        if (active_q && x_q == x1_i && y_q == y1_i) begin
          active_q <= 1'b0;
        end
        if (done_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // window position
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x0_i;
      y_q <= y0_i;
    end else if (active_q) begin
      if (x_q == x1_i) begin
        x_q <= x0_i;
        y_q <= y_q + AW'(1);
      end else begin
        x_q <= x_q + AW'(1);
      end
    end
  end

  // distance pipe: offsets, squares, then sum and keep the least
  always_ff @(posedge clk_i) begin
    s1_dx_q  <= dx_full[DXW-1:0];
    s1_dy_q  <= dy_full[DXW-1:0];
    s2_hit_q <= (rd_data_i != cls_q);
    sqx_q    <= sqx_full[BW-1:0];
    sqy_q    <= sqy_full[BW-1:0];
    if (ctl_i.start) begin
      cls_q  <= ctl_i.cls;
      best_q <= best_init_i;
    end else if (take) begin
      best_q <= d2[BW-1:0];
    end
  end

endmodule

// ===== sv/signed_distance_field_pixel_top.sv =====
// ----------------------------------------------------------------------------
// signed_distance_field_pixel_top
// Brute-force signed distance field of a one-bit bitmap, one pixel a query.
// ----------------------------------------------------------------------------
// A load beat writes one bitmap bit when it falls inside the map, and the
// input stays ready for the next beat. The window of radius spread, clipped
// to the bitmap, is read through the single bitmap read port at one pixel a
// cycle; a query with an empty clipped window skips the scan. After the scan,
// a square root of one result bit a cycle and a nine-step scaling run on one
// shared subtractor. The input is not ready during a query, and a query holds
// in its last state while the previous result still waits to be taken. The
// result sits in an output register, so loads keep flowing while it waits to
// be taken. The bitmap has no reset; every pixel read must have been loaded
// first.
// ----------------------------------------------------------------------------
module signed_distance_field_pixel_top #(
  parameter int MAX_DIM    = 1024,
  parameter int MAX_SPREAD = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sdf_cfg_if.sink  cfg_i,
  sdf_in_if.sink   in_i,
  sdf_out_if.source out_o
);
  import sdf_pkg::*;

  localparam int AW       = $clog2(MAX_DIM);
  localparam int CW       = COORD_WORK_W;
  localparam int SPW      = $clog2(MAX_SPREAD + 1);
  localparam int BW       = 2 * SPW;
  localparam int N        = (BW + 33) / 2;
  localparam int RADW     = 2 * N;
  localparam int REMW     = N + 3;
  localparam int DVW      = SPW + 9;
  localparam int ALUW     = (REMW > DVW) ? REMW : DVW;
  localparam int NUMW     = SPW + 26;
  localparam int CNTW     = $clog2(N + 1);
  localparam int DIV_SHIFT = FRAC_BITS + 1;

  localparam logic signed [CW-1:0] MAX_DIM_S = CW'(MAX_DIM);
  localparam logic [11:0]          MAX_SP_L  = 12'(MAX_SPREAD);

  state_e state_q, state_d;

  // configuration
  logic [DIM_CFG_W-1:0]    width_q, height_q;
  logic [SPREAD_CFG_W-1:0] spread_q;

  // query registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic [AW-1:0]        x0_q, x1_q, y0_q, y1_q;
  logic                 empty_q, in_map_q, cls_q;
  logic [SPW-1:0]       sp_q;
  logic [BW-1:0]        best_q;

  // iteration registers
  logic [RADW-1:0]      rad_q;
  logic [ALUW-1:0]      rem_q, dvs_q;
  logic [N-1:0]         root_q;
  logic [CNTW-1:0]      cnt_q;
  logic [NUMW-1:0]      base_q, delta_q;
  logic [DIV_STEPS-1:0] quo_q;
  logic                 out_valid_q;
  logic [DV_W-1:0]      dv_q;

  // sequencer outputs
  logic      in_ready, class_re, out_load;
  scan_ctl_t scan_ctl;

  // ---------------------------------------------------------------- geometry
  logic signed [CW-1:0] cx_in, cy_in, w_ext, h_ext, w_eff, h_eff, sp_s;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, x0, x1, y0, y1;
  logic [11:0]          sp_ext, sp_sel;
  logic [SPW-1:0]       sp_eff;
  logic [BW-1:0]        sp_wide;
  logic                 in_map, accept, cfg_write;

  assign cx_in = {{(CW-COORD_W){in_i.coord_x[COORD_W-1]}}, in_i.coord_x};
  assign cy_in = {{(CW-COORD_W){in_i.coord_y[COORD_W-1]}}, in_i.coord_y};

  // dimensions saturate at the store size
  assign w_ext = $signed(CW'(width_q));
  assign h_ext = $signed(CW'(height_q));
  assign w_eff = (w_ext > MAX_DIM_S) ? MAX_DIM_S : w_ext;
  assign h_eff = (h_ext > MAX_DIM_S) ? MAX_DIM_S : h_ext;

  // zero spread acts as one, large spread saturates
  assign sp_ext = 12'(spread_q);
  assign sp_sel = (spread_q == '0) ? 12'd1 : ((sp_ext > MAX_SP_L) ? MAX_SP_L : sp_ext);
  assign sp_eff = sp_sel[SPW-1:0];
  assign sp_s   = $signed(CW'(sp_eff));
  assign sp_wide = BW'(sp_eff);

  assign in_map = !cx_in[CW-1] && (cx_in < w_eff) && !cy_in[CW-1] && (cy_in < h_eff);

  // window clipped to the bitmap
  assign lo_x = cx_in - sp_s;
  assign hi_x = cx_in + sp_s;
  assign lo_y = cy_in - sp_s;
  assign hi_y = cy_in + sp_s;
  assign x0 = lo_x[CW-1] ? '0 : lo_x;
  assign y0 = lo_y[CW-1] ? '0 : lo_y;
  assign x1 = (hi_x > w_eff - CW'(1)) ? w_eff - CW'(1) : hi_x;
  assign y1 = (hi_y > h_eff - CW'(1)) ? h_eff - CW'(1) : hi_y;

  assign accept    = in_i.valid && in_ready;
  assign cfg_write = cfg_i.valid && cfg_i.ready;

  // ---------------------------------------------------------------- bitmap
  logic                mem_we, mem_re, mem_rdata, scan_re, scan_done;
  logic [2*AW-1:0]     scan_addr, mem_raddr;
  logic [BW-1:0]       scan_best;

  assign mem_we    = accept && (in_i.kind == KIND_LOAD) && in_map;
  assign mem_re    = class_re || scan_re;
  assign mem_raddr = scan_re ? scan_addr : {cy_q[AW-1:0], cx_q[AW-1:0]};

  sdf_bitmap #(.MAX_DIM(MAX_DIM)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({cy_in[AW-1:0], cx_in[AW-1:0]}),
    .wdata_i (in_i.coverage != '0),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sdf_scan #(.MAX_DIM(MAX_DIM), .MAX_SPREAD(MAX_SPREAD)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .x0_i        (x0_q),
    .x1_i        (x1_q),
    .y0_i        (y0_q),
    .y1_i        (y1_q),
    .cx_i        (cx_q),
    .cy_i        (cy_q),
    .best_init_i (best_q),
    .rd_en_o     (scan_re),
    .rd_addr_o   (scan_addr),
    .rd_data_i   (mem_rdata),
    .done_o      (scan_done),
    .best_o      (scan_best)
  );

  // ---------------------------------------------------------------- shared unit
  logic [ALUW-1:0] alu_a, alu_b, alu_diff, rem_sh;
  logic            alu_ge;

  assign rem_sh = {rem_q[ALUW-3:0], rad_q[RADW-1 -: 2]};

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    if (state_q == ST_SQRT) begin
      alu_a = rem_sh;
      alu_b = ALUW'({root_q, 2'b01});
    end else if (state_q == ST_DIV) begin
      alu_a = rem_q;
      alu_b = dvs_q;
    end
  end

  sdf_alu #(.W(ALUW)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ge_o   (alu_ge),
    .diff_o (alu_diff)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && in_i.kind == KIND_QUERY) state_d = ST_READ;
      ST_READ:  state_d = ST_CLASS;
      ST_CLASS: state_d = empty_q ? ST_SQRT : ST_START;
      ST_START: state_d = ST_SCAN;
      ST_SCAN:  if (scan_done) state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == '0) state_d = ST_PREP;
      ST_PREP:  state_d = ST_MAP;
      ST_MAP:   state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready       = (state_q == ST_IDLE);
    class_re       = (state_q == ST_READ) && in_map_q;
    scan_ctl.start = (state_q == ST_START);
    scan_ctl.cls   = cls_q;
    out_load       = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      spread_q <= SPREAD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        CFG_WIDTH:  width_q  <= cfg_i.data[DIM_CFG_W-1:0];
        CFG_HEIGHT: height_q <= cfg_i.data[DIM_CFG_W-1:0];
        CFG_SPREAD: spread_q <= cfg_i.data[SPREAD_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic            sqrt_init;
  logic [BW-1:0]   best_src;
  logic [NUMW-1:0] num_d;

  assign sqrt_init = ((state_q == ST_CLASS) && empty_q) || ((state_q == ST_SCAN) && scan_done);
  assign best_src  = (state_q == ST_SCAN) ? scan_best : best_q;

  // biased numerator, clamped at zero on the outside side
  assign num_d = cls_q ? (base_q + delta_q)
                       : ((delta_q >= base_q) ? '0 : (base_q - delta_q));

  always_ff @(posedge clk_i) begin
    // latch query geometry
    if (accept && in_i.kind == KIND_QUERY) begin
      cx_q     <= cx_in;
      cy_q     <= cy_in;
      x0_q     <= x0[AW-1:0];
      x1_q     <= x1[AW-1:0];
      y0_q     <= y0[AW-1:0];
      y1_q     <= y1[AW-1:0];
      empty_q  <= (x0 > x1) || (y0 > y1);
      in_map_q <= in_map;
      sp_q     <= sp_eff;
      best_q   <= sp_wide * sp_wide;
    end

    // class of the query pixel; outside the map counts as outside
    if (state_q == ST_CLASS) begin
      cls_q <= in_map_q && mem_rdata;
    end

    if (state_q == ST_SCAN && scan_done) begin
      best_q <= scan_best;
    end

    // root of best << 32, one result bit a step
    if (sqrt_init) begin
      rad_q  <= RADW'({best_src, 32'h0});
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CNTW'(N - 1);
    end else if (state_q == ST_SQRT) begin
      rad_q  <= rad_q << 2;
      rem_q  <= alu_ge ? alu_diff : rem_sh;
      root_q <= {root_q[N-2:0], alu_ge};
      cnt_q  <= cnt_q - CNTW'(1);
    end

    // 255*2^16*sp and 510*root by shift and subtract
    if (state_q == ST_PREP) begin
      base_q  <= (NUMW'(sp_q) << (FRAC_BITS + 8)) - (NUMW'(sp_q) << FRAC_BITS);
      delta_q <= (NUMW'(root_q) << 9) - (NUMW'(root_q) << 1);
    end

    // divide by 2^17*sp: drop 17 bits, then restoring division by sp
    if (state_q == ST_MAP) begin
      rem_q <= ALUW'(num_d[NUMW-1:DIV_SHIFT]);
      dvs_q <= ALUW'(sp_q) << (DIV_STEPS - 1);
      quo_q <= '0;
      cnt_q <= CNTW'(DIV_STEPS - 1);
    end else if (state_q == ST_DIV) begin
      if (alu_ge) begin
        rem_q <= alu_diff;
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[DIV_STEPS-2:0], alu_ge};
      cnt_q <= cnt_q - CNTW'(1);
    end

    // result register, saturated to a byte
    if (out_load) begin
      dv_q <= quo_q[DIV_STEPS-1] ? '1 : quo_q[DV_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.distance_value = dv_q;

endmodule
